/* rtl/core/spwm_three_phase_duty_generator_defines.svh */
// Assertion macros for the three-phase sinusoidal PWM duty generator.
// Depends on nothing; included by the top level.
`ifndef SPWM_THREE_PHASE_DUTY_GENERATOR_DEFINES_SVH
`define SPWM_THREE_PHASE_DUTY_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SPWM_ASSERT_SAME(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);
`define SPWM_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);
`else
`define SPWM_ASSERT_SAME(label, clk, rstn, pre, post, msg)
`define SPWM_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

/* rtl/core/spwm_pkg.sv */
// Types and fixed constants of the three-phase sinusoidal PWM duty generator.
// Depends on nothing.
`default_nettype none

package spwm_pkg;

    localparam int POS_W     = 14;
    localparam int IDX_W     = 11;
    localparam int VAL_W     = 16;
    localparam int DUTY_W    = 16;
    localparam int OP_W      = 2;
    localparam int PHASE_W   = 2;
    localparam int PHASES    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_BITS = 16;
    localparam int DIV_SHIFT = 24;
    localparam int MOD_SHIFT = 32;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE     = 2'd0,
        OP_WRITE_SINE = 2'd1,
        OP_WRITE_COG  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_RATIO    = 2'd0,
        CFG_ROTATE_CCW    = 2'd1,
        CFG_ANTI_COGGING  = 2'd2,
        CFG_OUTPUT_ENABLE = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

/* rtl/core/spwm_three_phase_duty_generator.sv */
// Three-phase sinusoidal PWM duty generator: table index, sine and cogging lookup, duty math.
// A sample item's result passes through the stage registers and then the output register.
// Throughput: one item per cycle; the divider, modulo and table stages are fully pipelined,
// and the single-port table memories serve one read or one write per cycle.
// Input stalls only when both the output register and the skid slot hold results.
// Reset clears configuration and all valid flags; table contents are undefined until written.
`default_nettype none
`include "spwm_three_phase_duty_generator_defines.svh"

module spwm_three_phase_duty_generator #(
    parameter int ENC_DIVISIONS = 16384,
    parameter int COMPRESSION   = 8,
    parameter int PWM_BITS      = 11
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [spwm_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [spwm_pkg::DUTY_W-1:0]              cfg_data,
    input  wire logic                                     s_valid,
    output logic                                          s_ready,
    input  wire logic [spwm_pkg::OP_W-1:0]                s_op,
    input  wire logic [spwm_pkg::POS_W-1:0]               s_encoder_position,
    input  wire logic                                     s_table_direction,
    input  wire logic [spwm_pkg::PHASE_W-1:0]             s_table_phase,
    input  wire logic [spwm_pkg::IDX_W-1:0]               s_table_index,
    input  wire logic signed [spwm_pkg::VAL_W-1:0]        s_table_value,
    output logic                                          m_valid,
    input  wire logic                                     m_ready,
    output logic [PWM_BITS-1:0]                           m_phase_a_duty,
    output logic [PWM_BITS-1:0]                           m_phase_b_duty,
    output logic [PWM_BITS-1:0]                           m_phase_c_duty
);

    localparam int RES       = ENC_DIVISIONS / COMPRESSION;
    localparam int KW        = $clog2(RES);
    localparam int DEPTH     = 2 * RES;
    localparam int AW        = $clog2(DEPTH);
    localparam int WORD_BITS = PWM_BITS + 1;
    localparam int N_MAX     = 2 * ((1 << spwm_pkg::POS_W) - 1) + COMPRESSION;
    localparam int NW_RAW    = $clog2(N_MAX + 1);
    localparam int NW        = (NW_RAW > KW) ? NW_RAW : KW;

    localparam longint unsigned DIV_ONE = longint'(1) << spwm_pkg::DIV_SHIFT;
    localparam longint unsigned MOD_ONE = longint'(1) << spwm_pkg::MOD_SHIFT;
    localparam longint unsigned M1_L    = (DIV_ONE + 2 * COMPRESSION - 1) / (2 * COMPRESSION);
    localparam longint unsigned M2_L    = (MOD_ONE + RES - 1) / RES;
    localparam int M1W  = $clog2(M1_L + 1);
    localparam int M2W  = $clog2(M2_L + 1);
    localparam int P1W  = NW + M1W;
    localparam int P2W  = NW + M2W;
    localparam int RESW = $clog2(RES + 1);
    localparam int P3W  = NW + RESW;

    localparam int PW   = WORD_BITS + spwm_pkg::DUTY_W + 1;
    localparam int VW   = (WORD_BITS + 18 > 34) ? WORD_BITS + 18 : 34;
    localparam int RSH  = spwm_pkg::FRAC_BITS + 1;
    localparam int RW   = VW - RSH;

    localparam longint MAX_L   = (longint'(1) << PWM_BITS) - 1;
    localparam longint MID_L   = MAX_L * (longint'(1) << spwm_pkg::FRAC_BITS);
    localparam longint ROUND_L = MID_L + (longint'(1) << spwm_pkg::FRAC_BITS);

    localparam logic signed [VW-1:0] NEG_MID_V = VW'(-MID_L);
    localparam logic signed [VW-1:0] ROUND_V   = VW'(ROUND_L);
    localparam logic [RW-1:0]        MAX_R     = RW'(MAX_L);
    localparam logic [PWM_BITS-1:0]  MAX_D     = PWM_BITS'(MAX_L);
    localparam logic [PWM_BITS-1:0]  HALF_D    = PWM_BITS'(MAX_L >> 1);

    function automatic logic [AW-1:0] row_addr(input logic dir, input logic [KW-1:0] k);
        logic [AW-1:0] base;
        base = dir ? AW'(RES) : {AW{1'b0}};
        return AW'(k) + base;
    endfunction

    logic [spwm_pkg::DUTY_W-1:0] duty_ratio_reg;
    logic                        rotate_ccw_reg;
    logic                        anti_cogging_enable_reg;
    logic                        output_enable_reg;

    logic                                adv;

    logic                                st1_valid_reg;
    logic [spwm_pkg::OP_W-1:0]           st1_op_reg;
    logic                                st1_dir_reg;
    logic [spwm_pkg::PHASE_W-1:0]        st1_ph_reg;
    logic [spwm_pkg::IDX_W-1:0]          st1_idx_reg;
    logic [spwm_pkg::VAL_W-1:0]          st1_val_reg;
    logic [P1W-1:0]                      st1_prod_reg;

    logic                                st2_valid_reg;
    logic [spwm_pkg::OP_W-1:0]           st2_op_reg;
    logic                                st2_dir_reg;
    logic [spwm_pkg::PHASE_W-1:0]        st2_ph_reg;
    logic [spwm_pkg::IDX_W-1:0]          st2_idx_reg;
    logic [spwm_pkg::VAL_W-1:0]          st2_val_reg;
    logic [NW-1:0]                       st2_q_reg;
    logic [P2W-1:0]                      st2_prod_reg;

    logic                                st3_valid_reg;
    logic [spwm_pkg::OP_W-1:0]           st3_op_reg;
    logic                                st3_dir_reg;
    logic [spwm_pkg::PHASE_W-1:0]        st3_ph_reg;
    logic [spwm_pkg::IDX_W-1:0]          st3_idx_reg;
    logic [spwm_pkg::VAL_W-1:0]          st3_val_reg;
    logic [NW-1:0]                       st3_q_reg;
    logic [P3W-1:0]                      st3_prod_reg;

    logic                                st4_valid_reg;
    logic [2:0][WORD_BITS-1:0]           st4_row_reg;
    logic signed [spwm_pkg::VAL_W-1:0]   st4_corr_reg;

    logic                                st5_valid_reg;
    logic signed [PW-1:0]                st5_prod_reg [spwm_pkg::PHASES];
    logic signed [spwm_pkg::VAL_W-1:0]   st5_corr_reg;

    logic                                st6_valid_reg;
    logic signed [VW-1:0]                st6_sel_reg [spwm_pkg::PHASES];
    logic                                st6_pin_reg [spwm_pkg::PHASES];

    logic [2:0][WORD_BITS-1:0]           sine_mem [DEPTH];
    logic [spwm_pkg::VAL_W-1:0]          cog_mem [DEPTH];

    logic [NW-1:0]                       s_num;
    logic [NW-1:0]                       st1_q;
    logic [NW-1:0]                       st2_qq;
    logic [NW-1:0]                       st3_rem;
    logic [KW-1:0]                       st3_k;
    logic [AW-1:0]                       st3_rd_addr;
    logic [AW-1:0]                       st3_wr_addr;
    logic                                st3_idx_ok;
    logic                                st3_is_sample;
    logic [WORD_BITS-1:0]                st3_word;

    logic signed [PW-1:0]                st4_prod [spwm_pkg::PHASES];
    logic signed [VW-1:0]                st5_sel [spwm_pkg::PHASES];
    logic                                st5_pin [spwm_pkg::PHASES];
    logic [PWM_BITS-1:0]                 res_duty [spwm_pkg::PHASES];

    logic                                m_valid_reg;
    logic                                m_valid_next;
    logic                                skid_valid_reg;
    logic                                skid_valid_next;
    logic [PWM_BITS-1:0]                 out_duty_reg [spwm_pkg::PHASES];
    logic [PWM_BITS-1:0]                 skid_duty_reg [spwm_pkg::PHASES];
    logic                                res_valid;
    logic                                take;
    logic                                load_out;
    logic                                load_skid;
    logic                                out_from_skid;

    assign cfg_ready = 1'b1;
    assign adv       = !skid_valid_reg;
    assign s_ready   = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_ratio_reg          <= '0;
            rotate_ccw_reg          <= 1'b0;
            anti_cogging_enable_reg <= 1'b0;
            output_enable_reg       <= 1'b0;
        end else if (cfg_valid) begin
            unique case (spwm_pkg::cfg_index_t'(cfg_index))
                spwm_pkg::CFG_DUTY_RATIO:    duty_ratio_reg          <= cfg_data;
                spwm_pkg::CFG_ROTATE_CCW:    rotate_ccw_reg          <= cfg_data[0];
                spwm_pkg::CFG_ANTI_COGGING:  anti_cogging_enable_reg <= cfg_data[0];
                spwm_pkg::CFG_OUTPUT_ENABLE: output_enable_reg       <= cfg_data[0];
            endcase
        end
    end

    // Index = round(position / COMPRESSION) mod RES, done as two exact reciprocal multiplies.
    assign s_num  = NW'({s_encoder_position, 1'b0}) + NW'(COMPRESSION);
    assign st1_q  = NW'(st1_prod_reg >> spwm_pkg::DIV_SHIFT);
    assign st2_qq = NW'(st2_prod_reg >> spwm_pkg::MOD_SHIFT);
    assign st3_rem = st3_q_reg - NW'(st3_prod_reg);
    assign st3_k   = st3_rem[KW-1:0];

    assign st3_is_sample = (st3_op_reg == spwm_pkg::OP_SAMPLE);
    assign st3_idx_ok    = (32'(st3_idx_reg) < 32'(RES));
    assign st3_rd_addr   = row_addr(rotate_ccw_reg, st3_k);
    assign st3_wr_addr   = row_addr(st3_dir_reg, KW'(st3_idx_reg));
    assign st3_word      = WORD_BITS'({1'b0, st3_val_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
            st6_valid_reg <= 1'b0;
        end else if (adv) begin
            st1_valid_reg <= s_valid;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg && st3_is_sample;
            st5_valid_reg <= st4_valid_reg;
            st6_valid_reg <= st5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_op_reg   <= s_op;
            st1_dir_reg  <= s_table_direction;
            st1_ph_reg   <= s_table_phase;
            st1_idx_reg  <= s_table_index;
            st1_val_reg  <= s_table_value;
            st1_prod_reg <= P1W'(s_num) * P1W'(M1_L);

            st2_op_reg   <= st1_op_reg;
            st2_dir_reg  <= st1_dir_reg;
            st2_ph_reg   <= st1_ph_reg;
            st2_idx_reg  <= st1_idx_reg;
            st2_val_reg  <= st1_val_reg;
            st2_q_reg    <= st1_q;
            st2_prod_reg <= P2W'(st1_q) * P2W'(M2_L);

            st3_op_reg   <= st2_op_reg;
            st3_dir_reg  <= st2_dir_reg;
            st3_ph_reg   <= st2_ph_reg;
            st3_idx_reg  <= st2_idx_reg;
            st3_val_reg  <= st2_val_reg;
            st3_q_reg    <= st2_q_reg;
            st3_prod_reg <= P3W'(st2_qq) * P3W'(RES);
        end
    end

    // Reads and writes share stage three, so table accesses stay in item order.
    always_ff @(posedge aclk) begin
        if (adv && st3_valid_reg) begin
            if (st3_is_sample) begin
                st4_row_reg  <= sine_mem[st3_rd_addr];
                st4_corr_reg <= cog_mem[st3_rd_addr];
            end else if (st3_op_reg == spwm_pkg::OP_WRITE_SINE) begin
                if (st3_idx_ok && 32'(st3_ph_reg) < spwm_pkg::PHASES) begin
                    sine_mem[st3_wr_addr][st3_ph_reg] <= st3_word;
                end
            end else if (st3_op_reg == spwm_pkg::OP_WRITE_COG) begin
                if (st3_idx_ok) begin
                    cog_mem[st3_wr_addr] <= st3_val_reg;
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < spwm_pkg::PHASES; j++) begin
            st4_prod[j] = PW'($signed(st4_row_reg[j])) * PW'($signed({1'b0, duty_ratio_reg}));
        end
    end

    always_comb begin
        logic signed [VW-1:0] p;
        logic signed [VW-1:0] a;
        for (int j = 0; j < spwm_pkg::PHASES; j++) begin
            p = VW'(st5_prod_reg[j]);
            a = p + (VW'(st5_corr_reg) <<< spwm_pkg::FRAC_BITS);
            st5_pin[j] = anti_cogging_enable_reg &&
                         ((p[VW-1] && !a[VW-1] && a != '0) ||
                          (!p[VW-1] && p != '0 && a[VW-1]));
            st5_sel[j] = anti_cogging_enable_reg ? a : p;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < spwm_pkg::PHASES; j++) begin
                st5_prod_reg[j] <= st4_prod[j];
                st6_sel_reg[j]  <= st5_sel[j];
                st6_pin_reg[j]  <= st5_pin[j];
            end
            st5_corr_reg <= st4_corr_reg;
        end
    end

    always_comb begin
        logic signed [VW-1:0] s;
        logic [RW-1:0]        r;
        for (int j = 0; j < spwm_pkg::PHASES; j++) begin
            s = st6_sel_reg[j] + ROUND_V;
            r = s[VW-1:RSH];
            if (!output_enable_reg) begin
                res_duty[j] = '0;
            end else if (st6_pin_reg[j]) begin
                res_duty[j] = HALF_D;
            end else if (st6_sel_reg[j] <= NEG_MID_V) begin
                res_duty[j] = '0;
            end else if (r > MAX_R) begin
                res_duty[j] = MAX_D;
            end else begin
                res_duty[j] = PWM_BITS'(r);
            end
        end
    end

    assign res_valid = adv && st6_valid_reg;
    assign take      = m_valid_reg && m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        if (skid_valid_reg) begin
            if (take) begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            if (!m_valid_reg || take) begin
                load_out     = 1'b1;
                m_valid_next = 1'b1;
            end else begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (take) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < spwm_pkg::PHASES; j++) begin
            if (out_from_skid) begin
                out_duty_reg[j] <= skid_duty_reg[j];
            end else if (load_out) begin
                out_duty_reg[j] <= res_duty[j];
            end
            if (load_skid) begin
                skid_duty_reg[j] <= res_duty[j];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_phase_a_duty = out_duty_reg[0];
    assign m_phase_b_duty = out_duty_reg[1];
    assign m_phase_c_duty = out_duty_reg[2];

    `SPWM_ASSERT_SAME(a_skid_needs_output, aclk, aresetn, skid_valid_reg, m_valid_reg, "skid holds an item while the output register is empty")
    `SPWM_ASSERT_NEXT(a_skid_held, aclk, aresetn, skid_valid_reg && !m_ready, skid_valid_reg && m_valid_reg, "stalled skid item was lost")
    `SPWM_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, st1_valid_reg, "accepted item did not enter the pipeline")

endmodule

`default_nettype wire

/* dv/tb_spwm_three_phase_duty_generator.sv */
// Self-checking testbench for the three-phase sinusoidal PWM duty generator.
// A duty predictor class tracks the tables and registers; needs spwm_pkg and the RTL top.
`timescale 1ns / 1ps

localparam int ENC_DIV     = 16384;
localparam int COMP        = 8;
localparam int PWM_W       = 11;
localparam int TABLE_DEPTH = ENC_DIV / COMP;
localparam int FULL_SCALE  = (1 << PWM_W) - 1;

localparam logic [spwm_pkg::OP_W-1:0]    OP_UNUSED = 2'd3;
localparam logic [spwm_pkg::PHASE_W-1:0] PHASE_A   = 2'd0;
localparam logic [spwm_pkg::PHASE_W-1:0] PHASE_B   = 2'd1;
localparam logic [spwm_pkg::PHASE_W-1:0] PHASE_C   = 2'd2;
localparam logic [spwm_pkg::PHASE_W-1:0] PHASE_BAD = 2'd3;
localparam logic DIR_CW  = 1'b0;
localparam logic DIR_CCW = 1'b1;

typedef struct {
    logic [spwm_pkg::OP_W-1:0]           op;
    logic [spwm_pkg::POS_W-1:0]          pos;
    logic                                dir;
    logic [spwm_pkg::PHASE_W-1:0]        phase;
    logic [spwm_pkg::IDX_W-1:0]          idx;
    logic signed [spwm_pkg::VAL_W-1:0]   value;
} duty_item_t;

typedef struct packed {
    logic [PWM_W-1:0] a;
    logic [PWM_W-1:0] b;
    logic [PWM_W-1:0] c;
} duty_set_t;

class duty_predictor;
    logic [15:0]       duty_ratio;
    bit                rotate_ccw;
    bit                cogging_on;
    bit                output_on;
    logic signed [PWM_W:0] sine_word [2][3][TABLE_DEPTH];
    logic signed [15:0]    cog_word [2][TABLE_DEPTH];
    duty_set_t         pending_duties[$];
    int unsigned       fail_count;

    function new();
        duty_ratio = '0;
        rotate_ccw = 1'b0;
        cogging_on = 1'b0;
        output_on  = 1'b0;
        fail_count = 0;
    endfunction

    function void write_register(spwm_pkg::cfg_index_t index, logic [15:0] data);
        case (index)
            spwm_pkg::CFG_DUTY_RATIO:    duty_ratio = data;
            spwm_pkg::CFG_ROTATE_CCW:    rotate_ccw = data[0];
            spwm_pkg::CFG_ANTI_COGGING:  cogging_on = data[0];
            spwm_pkg::CFG_OUTPUT_ENABLE: output_on  = data[0];
            default: ;
        endcase
    endfunction

    function logic [PWM_W-1:0] phase_duty(longint word, longint corr);
        longint mid_v;
        longint pre_v;
        longint post_v;
        longint v;
        longint r;
        mid_v = longint'(FULL_SCALE) * 65536;
        pre_v = word * longint'(duty_ratio) + mid_v;
        v = pre_v;
        if (cogging_on) begin
            post_v = pre_v + corr * 65536;
            if ((pre_v < mid_v && post_v > mid_v) || (pre_v > mid_v && post_v < mid_v))
                return PWM_W'(FULL_SCALE >> 1);
            v = post_v;
        end
        if (v <= 0)
            return '0;
        r = (v + 65536) >>> 17;
        if (r > FULL_SCALE)
            r = FULL_SCALE;
        return r[PWM_W-1:0];
    endfunction

    function void accept_item(duty_item_t it);
        int k;
        int d;
        longint corr;
        duty_set_t expect_set;
        case (it.op)
            spwm_pkg::OP_WRITE_SINE: begin
                if (it.phase != PHASE_BAD && it.idx < TABLE_DEPTH)
                    sine_word[it.dir][it.phase][it.idx] = it.value[PWM_W:0];
            end
            spwm_pkg::OP_WRITE_COG: begin
                if (it.idx < TABLE_DEPTH)
                    cog_word[it.dir][it.idx] = it.value;
            end
            spwm_pkg::OP_SAMPLE: begin
                if (!output_on) begin
                    expect_set = '0;
                end else begin
                    k = ((2 * int'(it.pos) + COMP) / (2 * COMP)) % TABLE_DEPTH;
                    d = rotate_ccw;
                    corr = longint'(cog_word[d][k]);
                    expect_set.a = phase_duty(longint'(sine_word[d][PHASE_A][k]), corr);
                    expect_set.b = phase_duty(longint'(sine_word[d][PHASE_B][k]), corr);
                    expect_set.c = phase_duty(longint'(sine_word[d][PHASE_C][k]), corr);
                end
                pending_duties.push_back(expect_set);
            end
            default: ;
        endcase
    endfunction

    function void check_duties(logic [PWM_W-1:0] a, logic [PWM_W-1:0] b,
                               logic [PWM_W-1:0] c);
        duty_set_t want;
        if (pending_duties.size() == 0) begin
            $error("result with no item waiting: a=%0d b=%0d c=%0d", a, b, c);
            fail_count++;
            return;
        end
        want = pending_duties.pop_front();
        if (a !== want.a) begin
            $error("phase_a_duty: expected %0d, actual %0d", want.a, a);
            fail_count++;
        end
        if (b !== want.b) begin
            $error("phase_b_duty: expected %0d, actual %0d", want.b, b);
            fail_count++;
        end
        if (c !== want.c) begin
            $error("phase_c_duty: expected %0d, actual %0d", want.c, c);
            fail_count++;
        end
    endfunction

    function int waiting();
        return pending_duties.size();
    endfunction
endclass

module tb_spwm_three_phase_duty_generator;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int NUM_SETTINGS    = 7;

    typedef struct {
        logic [15:0] duty;
        bit          ccw;
        bit          cog;
        bit          oe;
    } drive_setting_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [spwm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [spwm_pkg::DUTY_W-1:0]    cfg_data;
    logic s_valid;
    logic s_ready;
    logic [spwm_pkg::OP_W-1:0]         s_op;
    logic [spwm_pkg::POS_W-1:0]        s_encoder_position;
    logic                              s_table_direction;
    logic [spwm_pkg::PHASE_W-1:0]      s_table_phase;
    logic [spwm_pkg::IDX_W-1:0]        s_table_index;
    logic signed [spwm_pkg::VAL_W-1:0] s_table_value;
    logic m_valid;
    logic m_ready;
    logic [PWM_W-1:0] m_phase_a_duty;
    logic [PWM_W-1:0] m_phase_b_duty;
    logic [PWM_W-1:0] m_phase_c_duty;

    duty_predictor pred = new();

    bit sine_seen [2][3][TABLE_DEPTH];
    bit cog_seen [2][TABLE_DEPTH];
    bit index_ready [2][TABLE_DEPTH];
    int ready_list [2][$];
    bit cur_ccw;
    bit input_held;
    bit burst_mode;
    int counted_items;
    int idle_cycles;
    drive_setting_t settings [NUM_SETTINGS];

    spwm_three_phase_duty_generator #(
        .ENC_DIVISIONS(ENC_DIV),
        .COMPRESSION(COMP),
        .PWM_BITS(PWM_W)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_encoder_position(s_encoder_position),
        .s_table_direction(s_table_direction),
        .s_table_phase(s_table_phase),
        .s_table_index(s_table_index),
        .s_table_value(s_table_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_phase_a_duty(m_phase_a_duty),
        .m_phase_b_duty(m_phase_b_duty),
        .m_phase_c_duty(m_phase_c_duty)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pred.check_duties(m_phase_a_duty, m_phase_b_duty, m_phase_c_duty);
    end

    function automatic int pick_gap(bit no_gaps);
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    initial begin
        int run;
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            run = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(1, 8);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = pick_gap(1'b0);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    function automatic duty_item_t noise_item();
        duty_item_t it;
        it.op    = 2'($urandom_range(0, 3));
        it.pos   = 14'($urandom());
        it.dir   = 1'($urandom());
        it.phase = 2'($urandom());
        it.idx   = 11'($urandom());
        it.value = 16'($urandom());
        return it;
    endfunction

    function automatic logic [spwm_pkg::POS_W-1:0] position_for(int k);
        int p;
        p = (COMP * k + ENC_DIV + int'($urandom_range(0, COMP - 1)) - COMP / 2) % ENC_DIV;
        return p[spwm_pkg::POS_W-1:0];
    endfunction

    function automatic int pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return ($urandom_range(0, 1) == 0) ? 0 : TABLE_DEPTH - 1;
        if (r < 70)
            return $urandom_range(0, 47);
        return $urandom_range(0, TABLE_DEPTH - 1);
    endfunction

    function automatic void track_table(duty_item_t it);
        int d;
        if (it.op == spwm_pkg::OP_WRITE_SINE && it.phase != PHASE_BAD)
            sine_seen[it.dir][it.phase][it.idx] = 1'b1;
        else if (it.op == spwm_pkg::OP_WRITE_COG)
            cog_seen[it.dir][it.idx] = 1'b1;
        else
            return;
        d = it.dir;
        if (!index_ready[d][it.idx] && cog_seen[d][it.idx] && sine_seen[d][PHASE_A][it.idx]
                && sine_seen[d][PHASE_B][it.idx] && sine_seen[d][PHASE_C][it.idx]) begin
            index_ready[d][it.idx] = 1'b1;
            ready_list[d].push_back(int'(it.idx));
        end
    endfunction

    task automatic send_item(input duty_item_t it);
        int gap;
        s_valid            <= 1'b1;
        s_op               <= it.op;
        s_encoder_position <= it.pos;
        s_table_direction  <= it.dir;
        s_table_phase      <= it.phase;
        s_table_index      <= it.idx;
        s_table_value      <= it.value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred.accept_item(it);
        track_table(it);
        if (it.op != OP_UNUSED && !(it.op == spwm_pkg::OP_WRITE_SINE && it.phase == PHASE_BAD))
            counted_items++;
        gap = pick_gap(burst_mode);
        if (gap > 0) begin
            s_valid <= 1'b0;
            input_held = 1'b0;
            repeat (gap) @(posedge aclk);
        end else begin
            input_held = 1'b1;
        end
    endtask

    task automatic write_entry(input logic [spwm_pkg::OP_W-1:0] op, input logic dir,
                               input logic [spwm_pkg::PHASE_W-1:0] phase, input int k,
                               input logic [15:0] value);
        duty_item_t it;
        it       = noise_item();
        it.op    = op;
        it.dir   = dir;
        it.phase = phase;
        it.idx   = k[spwm_pkg::IDX_W-1:0];
        it.value = value;
        send_item(it);
    endtask

    task automatic sample_at(input logic [spwm_pkg::POS_W-1:0] pos);
        duty_item_t it;
        it     = noise_item();
        it.op  = spwm_pkg::OP_SAMPLE;
        it.pos = pos;
        send_item(it);
    endtask

    task automatic fill_index(input int k);
        int d;
        for (d = 0; d < 2; d++) begin
            write_entry(spwm_pkg::OP_WRITE_SINE, d[0], PHASE_A, k, 16'($urandom()));
            write_entry(spwm_pkg::OP_WRITE_SINE, d[0], PHASE_B, k, 16'($urandom()));
            write_entry(spwm_pkg::OP_WRITE_SINE, d[0], PHASE_C, k, 16'($urandom()));
            write_entry(spwm_pkg::OP_WRITE_COG, d[0], PHASE_A, k, 16'($urandom()));
        end
    endtask

    task automatic release_input();
        if (input_held) begin
            s_valid <= 1'b0;
            input_held = 1'b0;
        end
    endtask

    task automatic drain();
        release_input();
        while (pred.waiting() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(input drive_setting_t st);
        logic [15:0] words [4];
        int i;
        words[0] = st.duty;
        words[1] = {15'($urandom()), st.ccw};
        words[2] = {15'($urandom()), st.cog};
        words[3] = {15'($urandom()), st.oe};
        for (i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= spwm_pkg::cfg_index_t'(i);
            cfg_data  <= words[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            pred.write_register(spwm_pkg::cfg_index_t'(i), words[i]);
        end
        cfg_valid <= 1'b0;
        cur_ccw = st.ccw;
    endtask

    task automatic run_random_phase();
        int goal;
        int r;
        int n;
        int k;
        duty_item_t it;
        goal = counted_items + ITEMS_PER_PHASE;
        while (counted_items < goal) begin
            burst_mode = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 40 || (r < 75 && ready_list[cur_ccw].size() == 0)) begin
                k = pick_index();
                fill_index(k);
                n = $urandom_range(1, 3);
                repeat (n) sample_at(position_for(k));
            end else if (r < 75) begin
                k = ready_list[cur_ccw][$urandom_range(0, ready_list[cur_ccw].size() - 1)];
                sample_at(position_for(k));
            end else if (r < 88) begin
                write_entry(spwm_pkg::OP_WRITE_SINE, 1'($urandom()), 2'($urandom_range(0, 2)),
                            pick_index(), 16'($urandom()));
            end else if (r < 93) begin
                write_entry(spwm_pkg::OP_WRITE_COG, 1'($urandom()), 2'($urandom()),
                            pick_index(), 16'($urandom()));
            end else if (r < 97) begin
                it    = noise_item();
                it.op = OP_UNUSED;
                send_item(it);
            end else begin
                write_entry(spwm_pkg::OP_WRITE_SINE, 1'($urandom()), PHASE_BAD,
                            pick_index(), 16'($urandom()));
            end
        end
    endtask

    initial begin
        int i;
        aresetn            <= 1'b0;
        cfg_valid          <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        s_valid            <= 1'b0;
        s_op               <= spwm_pkg::OP_SAMPLE;
        s_encoder_position <= '0;
        s_table_direction  <= DIR_CW;
        s_table_phase      <= PHASE_A;
        s_table_index      <= '0;
        s_table_value      <= '0;
        input_held    = 1'b0;
        burst_mode    = 1'b0;
        counted_items = 0;
        cur_ccw       = 1'b0;

        settings[0] = '{16'hFFFF, 1'b1, 1'b1, 1'b1};
        settings[1] = '{16'h0000, 1'b0, 1'b1, 1'b1};
        settings[2] = '{16'h8000, 1'b1, 1'b0, 1'b1};
        settings[3] = '{16'($urandom()), 1'b0, 1'b1, 1'b0};
        settings[4] = '{16'($urandom()), 1'b1, 1'b1, 1'b1};
        settings[5] = '{16'hFFFF, 1'b0, 1'b1, 1'b1};
        settings[6] = '{16'h0001, 1'b0, 1'b0, 1'b1};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: table word extremes and wrap, index and position wrap at both ends.
        apply_setting('{16'hFFFF, 1'b0, 1'b0, 1'b1});
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CW, PHASE_A, 0, 16'h07FF);
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CW, PHASE_B, 0, 16'h0800);
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CW, PHASE_C, 0, 16'h7FFF);
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CW, PHASE_A, TABLE_DEPTH - 1, 16'h8000);
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CW, PHASE_B, TABLE_DEPTH - 1, 16'hFFFF);
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CW, PHASE_C, TABLE_DEPTH - 1, 16'h0C00);
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CCW, PHASE_A, 0, 16'hF801);
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CCW, PHASE_B, 0, 16'h0000);
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CCW, PHASE_C, 0, 16'h0400);
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CCW, PHASE_A, TABLE_DEPTH - 1, 16'h0001);
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CCW, PHASE_B, TABLE_DEPTH - 1, 16'h5555);
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CCW, PHASE_C, TABLE_DEPTH - 1, 16'hAAAA);
        write_entry(spwm_pkg::OP_WRITE_COG, DIR_CW, PHASE_A, 0, 16'h7FFF);
        write_entry(spwm_pkg::OP_WRITE_COG, DIR_CW, PHASE_A, TABLE_DEPTH - 1, 16'h8000);
        write_entry(spwm_pkg::OP_WRITE_COG, DIR_CCW, PHASE_A, 0, 16'h0000);
        write_entry(spwm_pkg::OP_WRITE_COG, DIR_CCW, PHASE_A, TABLE_DEPTH - 1, 16'hFFFF);
        write_entry(spwm_pkg::OP_WRITE_SINE, DIR_CW, PHASE_BAD, 0, 16'h0000);
        write_entry(OP_UNUSED, DIR_CW, PHASE_A, 0, 16'h1234);
        sample_at(14'd0);
        sample_at(14'd3);
        sample_at(14'd16379);
        sample_at(14'd16380);
        sample_at(14'd16383);

        for (i = 0; i < NUM_SETTINGS; i++) begin
            drain();
            apply_setting(settings[i]);
            run_random_phase();
        end

        release_input();
        while (pred.waiting() != 0) @(posedge aclk);
        repeat (4 * DRAIN_CYCLES) @(posedge aclk);
        if (pred.fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
